// ===== hw/rtl/mau_pkg.sv =====
// Shared types, constants and opcodes for the modular arithmetic unit.
package mau_pkg;
	localparam int W = 32;
	localparam int EW = 64;
	localparam logic [31:0] MOD_RESET = 32'd998244353;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_INV = 3'd4,
		OP_POW = 3'd5
	} op_t;

	// shared unit commands
	typedef enum logic [1:0] {
		U_MODRED,
		U_MULMOD,
		U_DIV
	} ucmd_t;

	typedef struct packed {
		logic          start;
		ucmd_t         cmd;
		logic [EW-1:0] x;
		logic [W-1:0]  y;
		logic [W-1:0]  m;
	} ureq_t;

	typedef struct packed {
		logic          done;
		logic [EW-1:0] q;
		logic [W-1:0]  r;
	} ursp_t;
endpackage

// ===== hw/rtl/mau_if.sv =====
// Valid/ready channel interfaces for request and result items.
interface mau_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [31:0] operand_a;
	logic [31:0] operand_b;
	logic [63:0] exponent;
	modport source (output valid, func, operand_a, operand_b, exponent, input ready);
	modport sink (input valid, func, operand_a, operand_b, exponent, output ready);
endinterface

interface mau_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] result;
	logic        no_inverse;
	logic        equal;
	modport source (output valid, result, no_inverse, equal, input ready);
	modport sink (input valid, result, no_inverse, equal, output ready);
endinterface

// ===== hw/rtl/mau_unit.sv =====
// Shared bit-serial unit: restoring divide/remainder and shift-add modular multiply.
module mau_unit import mau_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  ureq_t req,
	output ursp_t rsp
);
	typedef enum logic [1:0] {S_IDLE, S_DIV, S_MUL, S_DONE} st_t;
	st_t            st_q;
	logic [6:0]     cnt_q;
	logic [EW-1:0]  x_q;
	logic [EW-1:0]  q_q;
	logic [W:0]     r_q;
	logic [W-1:0]   y_q;
	logic [W-1:0]   m_q;
	logic [W:0]     rs, dbl, sum;
	logic [W+1:0]   sum2;
	logic [W:0]     acc_n;

	always_comb begin
		rs   = {r_q[W-1:0], x_q[EW-1]};
		dbl  = {x_q[W-1:0], 1'b0};
		sum2 = {1'b0, r_q} + {2'b0, x_q[W-1:0]};
		acc_n = (sum2 >= {2'b0, m_q}) ? (W+1)'(sum2 - {2'b0, m_q}) : sum2[W:0];
		sum  = dbl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: if (req.start) begin
					m_q <= req.m;
					y_q <= req.y;
					r_q <= '0;
					q_q <= '0;
					if (req.cmd == U_MULMOD) begin
						x_q   <= req.x;
						cnt_q <= 7'(W);
						st_q  <= S_MUL;
					end else begin
						x_q   <= req.x;
						cnt_q <= 7'(EW);
						st_q  <= S_DIV;
					end
				end
				S_DIV: begin
					// one quotient bit per cycle
					x_q <= x_q << 1;
					if (rs >= {1'b0, y_q}) begin
						r_q <= rs - {1'b0, y_q};
						q_q <= {q_q[EW-2:0], 1'b1};
					end else begin
						r_q <= rs;
						q_q <= {q_q[EW-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) st_q <= S_DONE;
				end
				S_MUL: begin
					// acc += x when the low multiplier bit is set; x doubles mod m
					if (y_q[0]) r_q <= acc_n;
					x_q[W-1:0] <= (sum >= {1'b0, m_q}) ? W'(sum - {1'b0, m_q}) : sum[W-1:0];
					y_q <= y_q >> 1;
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) st_q <= S_DONE;
				end
				S_DONE: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.done = (st_q == S_DONE);
	assign rsp.q    = q_q;
	assign rsp.r    = r_q[W-1:0];
endmodule

// ===== hw/rtl/mau_seq.sv =====
// Sequencer: reduces operands, runs Euclid and square-and-multiply on the shared unit.
module mau_seq import mau_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [W-1:0] modulus,
	mau_req_if.sink     rq,
	mau_rsp_if.source   rs,
	output ureq_t       ureq,
	input  ursp_t       ursp
);
	typedef enum logic [4:0] {
		S_IDLE, S_RA, S_RB, S_DISP, S_ENEG, S_EDIV, S_EFIX,
		S_PCHK, S_PMUL, S_PSQ, S_EUQ, S_EUMUL, S_EUUPD, S_EUEND,
		S_DIVMUL, S_OUT
	} st_t;
	st_t            st_q;
	logic [2:0]     func_q;
	logic [W-1:0]   m_q, a_q, b_q;
	logic [EW-1:0]  e_q;
	logic           eneg_q;
	logic [W-1:0]   r0_q, r1_q, t0_q, t1_q, qm_q;
	logic [W-1:0]   acc_q, base_q;
	logic [W-1:0]   res_q;
	logic           noinv_q, eq_q, ovalid_q;
	logic           ns_q;
	logic [W-1:0]   t2;
	logic [W-1:0]   ex_m1;

	assign ex_m1 = m_q - W'(1);
	assign t2 = (t0_q >= ursp.r) ? t0_q - ursp.r : t0_q + (m_q - ursp.r);
	assign rq.ready = (st_q == S_IDLE) && !ovalid_q;
	assign rs.valid = ovalid_q;
	assign rs.result = res_q;
	assign rs.no_inverse = noinv_q;
	assign rs.equal = eq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			ovalid_q <= 1'b0;
			ns_q     <= 1'b0;
			ureq     <= '0;
		end else begin
			// a start pulse lasts one cycle; no command is issued in the cycle after one
			if (ureq.start) ureq.start <= 1'b0;
			if (ovalid_q && rs.ready) ovalid_q <= 1'b0;
			unique case (st_q)
				S_IDLE: if (rq.valid && rq.ready) begin
					func_q <= rq.func;
					m_q    <= modulus;
					e_q    <= rq.exponent;
					b_q    <= rq.operand_b;
					if (modulus < W'(2)) begin
						res_q <= '0; noinv_q <= 1'b0; eq_q <= 1'b1;
						st_q  <= S_OUT;
					end else begin
						ureq <= '{1'b1, U_DIV, EW'(rq.operand_a), modulus, modulus};
						ns_q <= 1'b0;
						st_q <= S_RA;
					end
				end
				S_RA: if (ursp.done) begin
					a_q  <= ursp.r;
					ureq <= '{1'b1, U_DIV, EW'(b_q), m_q, m_q};
					st_q <= S_RB;
				end
				S_RB: if (ursp.done) begin
					b_q  <= ursp.r;
					st_q <= S_DISP;
				end
				S_DISP: begin
					eq_q <= (a_q == b_q); noinv_q <= 1'b0;
					case (func_q) inside
						OP_ADD: begin
							res_q <= ({1'b0, a_q} + {1'b0, b_q} >= {1'b0, m_q}) ?
								W'({1'b0, a_q} + {1'b0, b_q} - {1'b0, m_q}) : a_q + b_q;
							st_q <= S_OUT;
						end
						OP_SUB: begin
							res_q <= (a_q >= b_q) ? a_q - b_q : a_q + (m_q - b_q);
							st_q <= S_OUT;
						end
						OP_MUL: begin
							ureq <= '{1'b1, U_MULMOD, EW'(a_q), b_q, m_q};
							st_q <= S_DIVMUL;
						end
						OP_DIV, OP_INV: begin
							r0_q <= m_q; t0_q <= '0; t1_q <= W'(1);
							r1_q <= (func_q == OP_DIV) ? b_q : a_q;
							st_q <= S_EUQ; ns_q <= 1'b1;
						end
						OP_POW: begin
							eneg_q <= e_q[EW-1];
							st_q <= S_ENEG;
						end
						default: begin
							res_q <= '0;
							st_q <= S_OUT;
						end
					endcase
				end
				S_ENEG: begin
					if (eneg_q) e_q <= ~e_q + EW'(1);
					st_q <= S_EDIV;
					ns_q <= 1'b0;
				end
				S_EDIV: begin
					if (!ns_q) begin
						ureq <= '{1'b1, U_DIV, e_q, ex_m1, m_q};
						ns_q <= 1'b1;
					end else if (ursp.done) begin
						e_q  <= EW'((eneg_q && ursp.r != '0) ? ex_m1 - ursp.r : ursp.r);
						acc_q <= W'(1); base_q <= a_q;
						st_q <= S_PCHK;
					end
				end
				S_PCHK: begin
					if (a_q == '0) begin
						res_q <= '0; st_q <= S_OUT;
					end else if (e_q == '0) begin
						res_q <= acc_q; st_q <= S_OUT;
					end else if (e_q[0]) begin
						ureq <= '{1'b1, U_MULMOD, EW'(acc_q), base_q, m_q};
						st_q <= S_PMUL;
					end else begin
						ureq <= '{1'b1, U_MULMOD, EW'(base_q), base_q, m_q};
						st_q <= S_PSQ;
					end
				end
				S_PMUL: if (ursp.done) begin
					acc_q <= ursp.r;
					ureq <= '{1'b1, U_MULMOD, EW'(base_q), base_q, m_q};
					st_q <= S_PSQ;
				end
				S_PSQ: if (ursp.done) begin
					base_q <= ursp.r;
					e_q <= e_q >> 1;
					st_q <= S_PCHK;
				end
				S_EUQ: begin
					if (r1_q == '0) st_q <= S_EUEND;
					else if (ns_q) begin
						ureq <= '{1'b1, U_DIV, EW'(r0_q), r1_q, m_q};
						ns_q <= 1'b0;
					end else if (ursp.done) begin
						// q <= m since r0 <= m; q reaches m only when r1 is 1
						qm_q <= (ursp.q[W-1:0] >= m_q) ? ursp.q[W-1:0] - m_q : ursp.q[W-1:0];
						r0_q <= r1_q; r1_q <= ursp.r;
						st_q <= S_EUMUL;
					end
				end
				S_EUMUL: begin
					ureq <= '{1'b1, U_MULMOD, EW'(qm_q), t1_q, m_q};
					st_q <= S_EUUPD;
				end
				S_EUUPD: if (ursp.done) begin
					t0_q <= t1_q; t1_q <= t2;
					ns_q <= 1'b1;
					st_q <= S_EUQ;
				end
				S_EUEND: begin
					if (r0_q != W'(1)) begin
						noinv_q <= 1'b1; res_q <= '0; st_q <= S_OUT;
					end else if (func_q == OP_INV) begin
						res_q <= t0_q; st_q <= S_OUT;
					end else begin
						ureq <= '{1'b1, U_MULMOD, EW'(a_q), t0_q, m_q};
						st_q <= S_DIVMUL;
					end
				end
				S_DIVMUL: if (ursp.done) begin
					res_q <= ursp.r; st_q <= S_OUT;
				end
				S_OUT: if (!ovalid_q) begin
					ovalid_q <= 1'b1; st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== hw/rtl/modular_arithmetic_unit.sv =====
// Top level of the modular arithmetic unit.
// Usage:
//  - req channel (sink): func, operand_a, operand_b, exponent. A request is
//    taken when valid and ready are both high; ready is low while one
//    request is in work or its result has not yet been taken.
//  - rsp channel (source): result, no_inverse, equal; held until ready.
//  - cfg_we/cfg_wdata write the modulus (reset 998244353); write only while idle.
// Operation: both operands are reduced by a 64-step bit-serial divider;
// add/sub results follow directly, mul adds one 32-step modular multiply,
// power takes one 64-step exponent reduction plus up to 32 rounds of one or
// two 32-step modular multiplies (the reduced exponent is below 2^32), and
// inverse/div run Euclid with a 64-step divide and a 32-step multiply
// per round.
// All of this work is done on the one shared divide/multiply unit.
// Throughput: one request at a time; the next is taken after the result leaves.
// Reset: clears the sequencer and output valid; modulus returns to its default.
// Receiver stall: the result stays registered and no new request is taken.
module modular_arithmetic_unit import mau_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	mau_req_if.sink     req,
	mau_rsp_if.source   rsp
);
	logic [W-1:0] modulus_q;
	ureq_t        ureq;
	ursp_t        ursp;

	// hold modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) modulus_q <= MOD_RESET;
		else if (cfg_we) modulus_q <= cfg_wdata;
	end

	mau_seq u_seq (
		.clk(clk), .arst_n(arst_n), .modulus(modulus_q),
		.rq(req), .rs(rsp), .ureq(ureq), .ursp(ursp)
	);

	mau_unit u_unit (.clk(clk), .arst_n(arst_n), .req(ureq), .rsp(ursp));
endmodule

// ===== hw/rtl/mau_checker.sv =====
// Port-level checker for the modular arithmetic unit, bound to the top level.
module mau_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic rsp_no_inverse,
	input logic [31:0] rsp_result
);
	a_noinv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_no_inverse |-> rsp_result == 32'd0) else $error("no_inverse with result");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready) else $error("ready while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result)) else $error("result dropped");
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready) else $error("ready after accept");
endmodule

bind modular_arithmetic_unit mau_checker u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_no_inverse(rsp.no_inverse), .rsp_result(rsp.result)
);
